// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the event surface update unit.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Condition that must never be seen at a rising edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	`ASSERT_CLK(lbl, clk, rst_n, !(cond))

`endif

// ===== hdl/easu_pkg.sv =====
// Shared constants for the event surface update unit.
// Used by the front end, the surface engine and the top level; no dependencies.
package easu_pkg;

	localparam int X_W         = 10;
	localparam int Y_W         = 9;
	localparam int THRESH_W    = 20;
	localparam int STAMP_OUT_W = 32;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_READ   = 1'b1;

endpackage

// ===== hdl/easu_front.sv =====
// Front end: accepts requests, checks the pixel range and forms the memory address.
// Depends on easu_pkg; feeds the command queue.
module easu_front #(
	parameter int IMAGE_WIDTH  = 640,
	parameter int IMAGE_HEIGHT = 480,
	parameter int TIME_BITS    = 32,
	parameter int CMD_W        = 54
) (
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [easu_pkg::X_W-1:0]   pixel_x,
	input  logic [easu_pkg::Y_W-1:0]   pixel_y,
	input  logic                       event_polarity,
	input  logic [TIME_BITS-1:0]       event_time,
	input  logic                       q_full,
	input  logic                       clearing,
	output logic                       q_push,
	output logic [CMD_W-1:0]           q_data
);
	import easu_pkg::*;

	localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int PIX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;

	typedef struct packed {
		logic                 is_read;
		logic                 in_range;
		logic [PIX_W-1:0]     addr;
		logic                 pol;
		logic [TIME_BITS-1:0] stamp;
	} cmd_t;

	cmd_t cmd;
	logic in_range;

	always_comb begin
		in_range = (int'(pixel_x) < IMAGE_WIDTH) && (int'(pixel_y) < IMAGE_HEIGHT);
		cmd.is_read  = (opcode == OP_READ);
		cmd.in_range = in_range;
		cmd.addr     = in_range ? PIX_W'(int'(pixel_y) * IMAGE_WIDTH + int'(pixel_x))
		                        : '0;
		cmd.pol      = event_polarity;
		cmd.stamp    = event_time;
	end

	// hold off requests while the surface is being cleared or the queue is full
	assign in_stall = q_full || clearing;
	assign q_push   = in_valid && !in_stall;
	assign q_data   = cmd;

endmodule

// ===== hdl/easu_queue.sv =====
// Small command queue between the front end and the surface engine.
// Depends on assert_macros.svh; the payload is an opaque vector.
`include "assert_macros.svh"

module easu_queue #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 52
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_push_full, clk, arst_n, push && full)
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && !not_empty)
	`ASSERT_CLK(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH))

endmodule

// ===== hdl/easu_back.sv =====
// Surface engine: per-pixel stamp memory, clearing sweep, refractory filter, result register.
// Depends on easu_pkg and assert_macros.svh; drains the command queue.
`include "assert_macros.svh"

module easu_back #(
	parameter int IMAGE_WIDTH  = 640,
	parameter int IMAGE_HEIGHT = 480,
	parameter int TIME_BITS    = 32,
	parameter int CMD_W        = 54
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [easu_pkg::THRESH_W-1:0]       cfg_wdata,
	input  logic                                q_valid,
	input  logic [CMD_W-1:0]                    q_head,
	output logic                                q_pop,
	output logic                                clearing,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                event_accepted,
	output logic [easu_pkg::STAMP_OUT_W-1:0]    recent_stamp,
	output logic                                recent_is_positive,
	output logic [easu_pkg::STAMP_OUT_W-1:0]    newest_time
);
	import easu_pkg::*;

	localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int PIX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int SUM_W  = ((TIME_BITS > THRESH_W) ? TIME_BITS : THRESH_W) + 1;

	typedef struct packed {
		logic                 is_read;
		logic                 in_range;
		logic [PIX_W-1:0]     addr;
		logic                 pol;
		logic [TIME_BITS-1:0] stamp;
	} cmd_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] fpos;
		logic [TIME_BITS-1:0] fneg;
		logic [TIME_BITS-1:0] lpos;
		logic [TIME_BITS-1:0] lneg;
	} entry_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_EXEC
	} state_t;

	state_t               state_q;
	logic [PIX_W-1:0]     clr_q;
	cmd_t                 cmd_s1;
	entry_t               rd_s1;
	logic [THRESH_W-1:0]  thr_q;
	logic [TIME_BITS-1:0] newest_q;

	logic                   out_valid_q;
	logic                   out_acc_q;
	logic [STAMP_OUT_W-1:0] out_stamp_q;
	logic                   out_pos_q;
	logic [STAMP_OUT_W-1:0] out_newest_q;

	entry_t mem [PIXELS];

	cmd_t                 head_cmd;
	entry_t               new_entry, wr_data;
	logic [PIX_W-1:0]     wr_addr;
	logic                 mem_we;
	logic [TIME_BITS-1:0] own_last, other_last, nxt_newest, read_stamp;
	logic                 pass, do_write, can_load, pos_newer, out_load;

	assign head_cmd = cmd_t'(q_head);
	assign can_load = !out_valid_q || !out_stall;
	assign out_load = (state_q == B_EXEC) && can_load;
	assign q_pop    = (state_q == B_IDLE) && q_valid;
	assign clearing = (state_q == B_CLEAR);

	always_comb begin
		own_last   = cmd_s1.pol ? rd_s1.lpos : rd_s1.lneg;
		other_last = cmd_s1.pol ? rd_s1.lneg : rd_s1.lpos;
		// exact sum, one bit wider than the widest operand
		pass = (SUM_W'(cmd_s1.stamp) > SUM_W'(own_last) + SUM_W'(thr_q))
		       || (other_last > own_last);
		do_write = cmd_s1.in_range && !cmd_s1.is_read;

		new_entry = rd_s1;
		if (cmd_s1.pol) begin
			new_entry.lpos = cmd_s1.stamp;
			if (pass) begin
				new_entry.fpos = cmd_s1.stamp;
			end
		end else begin
			new_entry.lneg = cmd_s1.stamp;
			if (pass) begin
				new_entry.fneg = cmd_s1.stamp;
			end
		end

		pos_newer  = rd_s1.fpos > rd_s1.fneg;
		read_stamp = pos_newer ? rd_s1.fpos : rd_s1.fneg;
		nxt_newest = do_write ? cmd_s1.stamp : newest_q;

		mem_we  = clearing || (out_load && do_write);
		wr_addr = clearing ? clr_q : cmd_s1.addr;
		wr_data = clearing ? '0 : new_entry;
	end

	// write the stamp memory; hold the fetched entry while the request waits in execute
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (q_pop) begin
			rd_s1 <= mem[head_cmd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_CLEAR;
			clr_q        <= '0;
			cmd_s1       <= '0;
			newest_q     <= '0;
			out_valid_q  <= 1'b0;
			out_acc_q    <= 1'b0;
			out_stamp_q  <= '0;
			out_pos_q    <= 1'b0;
			out_newest_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PIX_W'(PIXELS - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (q_valid) begin
						cmd_s1  <= head_cmd;
						state_q <= B_EXEC;
					end
				end
				B_EXEC: begin
					// wait for a free result slot, then commit the write and the result
					if (can_load) begin
						out_acc_q    <= do_write && pass;
						out_stamp_q  <= (cmd_s1.is_read && cmd_s1.in_range)
						                ? STAMP_OUT_W'(read_stamp) : '0;
						out_pos_q    <= cmd_s1.is_read && cmd_s1.in_range && pos_newer;
						out_newest_q <= STAMP_OUT_W'(nxt_newest);
						newest_q     <= nxt_newest;
						state_q      <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign event_accepted     = out_acc_q;
	assign recent_stamp       = out_stamp_q;
	assign recent_is_positive = out_pos_q;
	assign newest_time        = out_newest_q;

	`ASSERT_NEVER(a_no_pop_in_clear, clk, arst_n, (state_q == B_CLEAR) && q_pop)
	`ASSERT_CLK(a_exec_commit, clk, arst_n, out_load |=> (state_q == B_IDLE) && out_valid_q)
	`ASSERT_CLK(a_update_no_stamp, clk, arst_n, out_valid_q && out_acc_q |-> (out_stamp_q == '0) && !out_pos_q)

endmodule

// ===== hdl/event_active_surface_update_unit.sv =====
// Top level of the event surface update unit: front end, command queue, surface engine.
// Depends on easu_pkg, easu_front, easu_queue and easu_back.
//
// Usage:
//   Request channel (in_valid / in_stall): opcode 0 updates the surface with an event
//   (pixel_x, pixel_y, event_polarity, event_time); opcode 1 reads the filtered surface
//   at a pixel. Every request yields exactly one result on the result channel
//   (out_valid / out_stall), in request order.
//   cfg_we / cfg_wdata write the refractory threshold; write it only while idle.
//   A taken request is written into the queue; the engine pops it in idle, reading its
//   stamp memory entry, and in execute, once the result register is free, writes the entry
//   back and loads the result; one request is handled at a time, the memory has one port.
//   A queue of QUEUE_DEPTH requests lets the front end keep taking requests while the
//   engine waits on a stalled result.
//   Reset: after arst_n rises the engine zeroes the stamp memory, one pixel per cycle,
//   all IMAGE_WIDTH * IMAGE_HEIGHT entries (307200 at defaults); in_stall stays high
//   meanwhile. Configuration writes are taken at any time.
//   When the receiver stalls, the result is held; the queue then fills and in_stall rises.
module event_active_surface_update_unit #(
	parameter int IMAGE_WIDTH  = 640,
	parameter int IMAGE_HEIGHT = 480,
	parameter int TIME_BITS    = 32,
	parameter int QUEUE_DEPTH  = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [easu_pkg::THRESH_W-1:0]    cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             opcode,
	input  logic [easu_pkg::X_W-1:0]         pixel_x,
	input  logic [easu_pkg::Y_W-1:0]         pixel_y,
	input  logic                             event_polarity,
	input  logic [TIME_BITS-1:0]             event_time,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             event_accepted,
	output logic [easu_pkg::STAMP_OUT_W-1:0] recent_stamp,
	output logic                             recent_is_positive,
	output logic [easu_pkg::STAMP_OUT_W-1:0] newest_time
);
	import easu_pkg::*;

	localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int PIX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int CMD_W  = 3 + PIX_W + TIME_BITS;

	logic             q_push, q_pop, q_full, q_not_empty, clearing;
	logic [CMD_W-1:0] q_in, q_head;

	easu_front #(
		.IMAGE_WIDTH (IMAGE_WIDTH),
		.IMAGE_HEIGHT(IMAGE_HEIGHT),
		.TIME_BITS   (TIME_BITS),
		.CMD_W       (CMD_W)
	) u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.event_polarity(event_polarity),
		.event_time    (event_time),
		.q_full        (q_full),
		.clearing      (clearing),
		.q_push        (q_push),
		.q_data        (q_in)
	);

	easu_queue #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(CMD_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head     (q_head)
	);

	easu_back #(
		.IMAGE_WIDTH (IMAGE_WIDTH),
		.IMAGE_HEIGHT(IMAGE_HEIGHT),
		.TIME_BITS   (TIME_BITS),
		.CMD_W       (CMD_W)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.q_valid           (q_not_empty),
		.q_head            (q_head),
		.q_pop             (q_pop),
		.clearing          (clearing),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.event_accepted    (event_accepted),
		.recent_stamp      (recent_stamp),
		.recent_is_positive(recent_is_positive),
		.newest_time       (newest_time)
	);

endmodule
